/* rtl/ndft_pkg.sv */
// Shared types, sizes and constants for the direct nonuniform DFT engine.
// Used by ndft_eval and the top level; depends on nothing.
package ndft_pkg;

  localparam int unsigned MaxSources = 1024;
  localparam int unsigned AddrW      = $clog2(MaxSources);
  localparam int unsigned CntW       = AddrW + 1;
  localparam int unsigned CoordW     = 24;
  localparam int unsigned SampW      = 16;
  localparam int unsigned SrcW       = 3 * CoordW + 2 * SampW;
  localparam int unsigned AccW       = 48;
  localparam int unsigned MulW       = 33;
  localparam int unsigned ProdW      = 2 * MulW;
  localparam int unsigned TermW      = 33;
  localparam int unsigned TrigW      = 17;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgW       = 2;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_EVAL  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  localparam logic [CfgIdxW-1:0] RegInverse = 1'b0;
  localparam logic [CfgIdxW-1:0] RegNumDims = 1'b1;

  localparam logic signed [MulW-1:0] Sc11 = 33'sd3864;

  typedef struct packed {
    logic            go;
    logic            inverse;
    logic [1:0]      dims;
    logic [CntW-1:0] count;
    logic            dropped;
  } eval_cmd_t;

  function automatic logic signed [MulW-1:0] poly_coef(input logic [2:0] step);
    logic signed [MulW-1:0] c;
    unique case (step)
      3'd1:    c = 33'sd172272;
      3'd2:    c = 33'sd5026996;
      3'd3:    c = 33'sd85569307;
      3'd4:    c = 33'sd693598667;
      3'd5:    c = 33'sd1686629713;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

/* rtl/ndft_ram.sv */
// Generic simple dual-port RAM with registered read data.
// No dependencies.
module ndft_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ndft_eval.sv */
// Evaluate sequencer: walks the stored sources with one shared multiplier
// for dot product, sine/cosine polynomial and complex multiply-accumulate.
// Depends on ndft_pkg.
module ndft_eval import ndft_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  eval_cmd_t                cmd_i,
  input  logic signed [CoordW-1:0] dst_x_i,
  input  logic signed [CoordW-1:0] dst_y_i,
  input  logic signed [CoordW-1:0] dst_z_i,
  input  logic [SrcW-1:0]          src_i,
  output logic [AddrW-1:0]         raddr_o,
  output logic                     busy_o,
  output logic                     done_o,
  output logic signed [AccW-1:0]   sum_re_o,
  output logic signed [AccW-1:0]   sum_im_o,
  output logic                     saturated_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_FETCH = 6'b000010,
    ST_DOT   = 6'b000100,
    ST_TRIG  = 6'b001000,
    ST_CPLX  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [2:0]      step_q, step_d;
  logic [1:0]      d_q, d_d;
  logic            half_q, half_d;
  logic [CntW-1:0] k_q, k_d;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      dims_q, dims_d;
  logic            inv_q, inv_d;
  logic            drop_q, drop_d;
  logic            sat_q, sat_d;
  logic [CoordW-1:0] dst_q [3];
  logic [CoordW-1:0] dst_d [3];
  logic [CoordW-1:0] dot_q, dot_d;
  logic [30:0]       x2_q, x2_d;
  logic signed [MulW-1:0]  p_q, p_d;
  logic [TrigW-1:0]        s0_q, s0_d, c0_q, c0_d;
  logic signed [TermW-1:0] t_q, t_d;
  logic signed [AccW-1:0]  acc_re_q, acc_re_d, acc_im_q, acc_im_d;

  logic signed [CoordW-1:0] src_c [3];
  logic signed [SampW-1:0]  smp_re, smp_im;
  logic [CoordW-1:0]        dot_n;
  logic [15:0]              phase;
  logic [30:0]              x_s, xa;
  logic signed [MulW-1:0]   p_cl;
  logic signed [MulW-1:0]   mul_a, mul_b;
  logic signed [ProdW-1:0]  prod;
  logic signed [MulW-1:0]   psh;
  logic [31:0]              rnd;
  logic [TrigW-1:0]         srnd;
  logic signed [TrigW-1:0]  cv, sv;
  logic signed [AccW:0]     acc_sum;
  logic signed [AccW-1:0]   acc_sel, acc_new;
  logic                     acc_ovf;

  assign src_c[0] = src_i[CoordW-1:0];
  assign src_c[1] = src_i[2*CoordW-1:CoordW];
  assign src_c[2] = src_i[3*CoordW-1:2*CoordW];
  assign smp_re   = src_i[3*CoordW+SampW-1:3*CoordW];
  assign smp_im   = src_i[SrcW-1:3*CoordW+SampW];

  assign dot_n = inv_q ? dot_q : (CoordW'(0) - dot_q);
  assign phase = dot_n[23:8];
  assign x_s   = {1'b0, phase[13:0], 16'b0};
  assign xa    = half_q ? (31'h4000_0000 - x_s) : x_s;
  assign p_cl  = p_q[MulW-1] ? '0 : p_q;

  always_comb begin
    unique case (phase[15:14])
      2'd0:    begin cv = c0_q;            sv = s0_q;            end
      2'd1:    begin cv = TrigW'(-s0_q);   sv = c0_q;            end
      2'd2:    begin cv = TrigW'(-c0_q);   sv = TrigW'(-s0_q);   end
      default: begin cv = s0_q;            sv = TrigW'(-c0_q);   end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_DOT: begin
        mul_a = MulW'(src_c[d_q]);
        mul_b = MulW'($signed(dst_q[d_q]));
      end
      ST_TRIG: begin
        if (step_q == 3'd0) begin
          mul_a = {2'b0, xa};
          mul_b = {2'b0, xa};
        end else if (step_q == 3'd6) begin
          mul_a = p_cl;
          mul_b = {2'b0, xa};
        end else begin
          mul_a = p_q;
          mul_b = {2'b0, x2_q};
        end
      end
      ST_CPLX: begin
        unique case (step_q)
          3'd0:    begin mul_a = MulW'(smp_re); mul_b = MulW'(cv); end
          3'd1:    begin mul_a = MulW'(smp_im); mul_b = MulW'(sv); end
          3'd2:    begin mul_a = MulW'(smp_re); mul_b = MulW'(sv); end
          3'd3:    begin mul_a = MulW'(smp_im); mul_b = MulW'(cv); end
          default: begin mul_a = '0;            mul_b = '0;        end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign psh  = prod[62:30];
  assign rnd  = psh[31:0] + 32'd16384;
  assign srnd = (rnd[31:15] > 17'd32768) ? 17'd32768 : rnd[31:15];

  assign acc_sel = (step_q == 3'd2) ? acc_re_q : acc_im_q;
  assign acc_sum = {acc_sel[AccW-1], acc_sel} + (AccW+1)'(t_q);
  assign acc_ovf = acc_sum[AccW] != acc_sum[AccW-1];
  always_comb begin
    if (!acc_ovf) begin
      acc_new = acc_sum[AccW-1:0];
    end else if (acc_sum[AccW]) begin
      acc_new = {1'b1, {(AccW-1){1'b0}}};
    end else begin
      acc_new = {1'b0, {(AccW-1){1'b1}}};
    end
  end

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    d_d      = d_q;
    half_d   = half_q;
    k_d      = k_q;
    cnt_d    = cnt_q;
    dims_d   = dims_q;
    inv_d    = inv_q;
    drop_d   = drop_q;
    sat_d    = sat_q;
    dst_d    = dst_q;
    dot_d    = dot_q;
    x2_d     = x2_q;
    p_d      = p_q;
    s0_d     = s0_q;
    c0_d     = c0_q;
    t_d      = t_q;
    acc_re_d = acc_re_q;
    acc_im_d = acc_im_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_i.go) begin
          cnt_d    = cmd_i.count;
          dims_d   = (cmd_i.dims == 2'd0) ? 2'd1 : cmd_i.dims;
          inv_d    = cmd_i.inverse;
          drop_d   = cmd_i.dropped;
          dst_d[0] = dst_x_i;
          dst_d[1] = dst_y_i;
          dst_d[2] = dst_z_i;
          sat_d    = 1'b0;
          acc_re_d = '0;
          acc_im_d = '0;
          k_d      = '0;
          d_d      = '0;
          dot_d    = '0;
          state_d  = (cmd_i.count == '0) ? ST_DONE : ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = ST_DOT;
      end
      ST_DOT: begin
        dot_d = dot_q + prod[CoordW-1:0];
        if (d_q == dims_q - 2'd1) begin
          state_d = ST_TRIG;
          step_d  = '0;
          half_d  = 1'b0;
          p_d     = Sc11;
        end else begin
          d_d = d_q + 2'd1;
        end
      end
      ST_TRIG: begin
        if (step_q == 3'd0) begin
          x2_d   = psh[30:0];
          step_d = step_q + 3'd1;
        end else if (step_q == 3'd6) begin
          if (half_q) begin
            c0_d    = srnd;
            state_d = ST_CPLX;
            step_d  = '0;
          end else begin
            s0_d   = srnd;
            half_d = 1'b1;
            step_d = '0;
            p_d    = Sc11;
          end
        end else begin
          p_d    = poly_coef(step_q) - psh;
          step_d = step_q + 3'd1;
        end
      end
      ST_CPLX: begin
        step_d = step_q + 3'd1;
        unique case (step_q)
          3'd0: t_d = prod[TermW-1:0];
          3'd1: t_d = t_q - prod[TermW-1:0];
          3'd2: begin
            acc_re_d = acc_new;
            sat_d    = sat_q | acc_ovf;
            t_d      = prod[TermW-1:0];
          end
          3'd3: t_d = t_q + prod[TermW-1:0];
          default: begin
            acc_im_d = acc_new;
            sat_d    = sat_q | acc_ovf;
            k_d      = k_q + CntW'(1);
            d_d      = '0;
            dot_d    = '0;
            state_d  = (k_q + CntW'(1) == cnt_q) ? ST_DONE : ST_FETCH;
          end
        endcase
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      d_q     <= '0;
      half_q  <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      d_q     <= d_d;
      half_q  <= half_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    dims_q   <= dims_d;
    inv_q    <= inv_d;
    drop_q   <= drop_d;
    sat_q    <= sat_d;
    dst_q    <= dst_d;
    dot_q    <= dot_d;
    x2_q     <= x2_d;
    p_q      <= p_d;
    s0_q     <= s0_d;
    c0_q     <= c0_d;
    t_q      <= t_d;
    acc_re_q <= acc_re_d;
    acc_im_q <= acc_im_d;
  end

  assign raddr_o     = k_q[AddrW-1:0];
  assign busy_o      = state_q != ST_IDLE;
  assign done_o      = state_q == ST_DONE;
  assign sum_re_o    = acc_re_q;
  assign sum_im_o    = acc_im_q;
  assign saturated_o = sat_q | drop_q;

endmodule

/* rtl/nonuniform_dft_direct_sum.sv */
// Direct nonuniform DFT engine, top level: command decode, source store,
// configuration registers. Depends on ndft_pkg, ndft_ram and ndft_eval.
//
// Usage: drive command_i and the payload ports and raise start; the item is
// taken at a clock edge where start is high and busy is low.
// Clear and load give no result; busy stays low.
// A load with the store full (1024 sources) is dropped and flagged.
// Evaluate raises busy and walks every stored source through one shared
// 33x33 multiplier: per source up to 3 dot product steps, 14 sine/cosine
// polynomial steps, 5 complex multiply-accumulate steps and one memory read.
// The result is shown for one cycle with done_o high, then busy drops.
// The receiver cannot stall; the result must be taken in that cycle.
// Configuration (cfg_we_i, cfg_idx_i, cfg_wdata_i) is written at once.
// Reset empties the source set, clears the dropped flag, sets inverse to 0
// and num_dims to 3; the source memory itself is not cleared.
module nonuniform_dft_direct_sum import ndft_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               command_i,
  input  logic signed [CoordW-1:0] coord_x_i,
  input  logic signed [CoordW-1:0] coord_y_i,
  input  logic signed [CoordW-1:0] coord_z_i,
  input  logic signed [SampW-1:0]  sample_re_i,
  input  logic signed [SampW-1:0]  sample_im_i,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [CfgW-1:0]          cfg_wdata_i,
  output logic                     done_o,
  output logic signed [AccW-1:0]   sum_re_o,
  output logic signed [AccW-1:0]   sum_im_o,
  output logic                     saturated_o
);

  logic            inverse_q, inverse_d;
  logic [1:0]      num_dims_q, num_dims_d;
  logic [CntW-1:0] count_q, count_d;
  logic            dropped_q, dropped_d;
  logic            accept, full, ram_we, eval_busy;
  cmd_e            cmd;
  eval_cmd_t       eval_cmd;
  logic [AddrW-1:0] raddr;
  logic [SrcW-1:0]  rdata;

  assign cmd    = cmd_e'(command_i);
  assign accept = start & ~eval_busy;
  assign full   = count_q == CntW'(MaxSources);
  assign ram_we = accept & (cmd == CMD_LOAD) & ~full;

  always_comb begin
    inverse_d  = inverse_q;
    num_dims_d = num_dims_q;
    count_d    = count_q;
    dropped_d  = dropped_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegInverse: inverse_d  = cfg_wdata_i[0];
        default:    num_dims_d = cfg_wdata_i;
      endcase
    end
    if (accept) begin
      unique case (cmd)
        CMD_CLEAR: begin
          count_d   = '0;
          dropped_d = 1'b0;
        end
        CMD_LOAD: begin
          if (full) begin
            dropped_d = 1'b1;
          end else begin
            count_d = count_q + CntW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inverse_q  <= 1'b0;
      num_dims_q <= 2'd3;
      count_q    <= '0;
      dropped_q  <= 1'b0;
    end else begin
      inverse_q  <= inverse_d;
      num_dims_q <= num_dims_d;
      count_q    <= count_d;
      dropped_q  <= dropped_d;
    end
  end

  assign eval_cmd.go      = accept & (cmd == CMD_EVAL);
  assign eval_cmd.inverse = inverse_q;
  assign eval_cmd.dims    = num_dims_q;
  assign eval_cmd.count   = count_q;
  assign eval_cmd.dropped = dropped_q;

  ndft_ram #(
    .Width(SrcW),
    .Depth(MaxSources)
  ) u_src_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i ({sample_im_i, sample_re_i, coord_z_i, coord_y_i, coord_x_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ndft_eval u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (eval_cmd),
    .dst_x_i     (coord_x_i),
    .dst_y_i     (coord_y_i),
    .dst_z_i     (coord_z_i),
    .src_i       (rdata),
    .raddr_o     (raddr),
    .busy_o      (eval_busy),
    .done_o      (done_o),
    .sum_re_o    (sum_re_o),
    .sum_im_o    (sum_im_o),
    .saturated_o (saturated_o)
  );

  assign busy = eval_busy;

endmodule
